[hdl/tbk_pkg.sv]
package tbk_pkg;

  localparam int TEMP_W     = 12;
  localparam int RANK_OUT_W = 3;

  typedef logic signed [TEMP_W-1:0] temp_t;

  localparam temp_t TEMP_MIN = -12'sd1600;
  localparam temp_t TEMP_MAX = 12'sd1120;

  // Mode codes carried on the input channel.
  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_REPORT = 1'b1;

  // List codes carried on the result channel.
  localparam logic LIST_HIGH = 1'b0;
  localparam logic LIST_LOW  = 1'b1;

  // What every cell of the chain does in a given cycle.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ROT_HI,
    OP_ROT_LO
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    temp_t    value;
  } cell_ctrl_t;

  // What a cell shows its neighbours: its entries and whether the reading on
  // offer belongs at or before its slot.
  typedef struct packed {
    temp_t hi_val;
    temp_t lo_val;
    logic  hi_hit;
    logic  lo_hit;
  } cell_link_t;

  localparam cell_link_t LINK_NONE = '{hi_val: '0, lo_val: '0, hi_hit: 1'b0, lo_hit: 1'b0};

endpackage

[hdl/tbk_if.sv]
interface tbk_in_if;
  logic                 valid;
  logic                 ready;
  logic                 mode;
  tbk_pkg::temp_t       temperature;

  modport source (output valid, output mode, output temperature, input ready);
  modport sink (input valid, input mode, input temperature, output ready);
endinterface

interface tbk_out_if;
  logic                                valid;
  logic                                ready;
  tbk_pkg::temp_t                      value;
  logic                                list_sel;
  logic [tbk_pkg::RANK_OUT_W-1:0]      rank;
  logic                                present;
  logic                                last;

  modport source (output valid, output value, output list_sel, output rank, output present,
                  output last, input ready);
  modport sink (input valid, input value, input list_sel, input rank, input present,
                input last, output ready);
endinterface

[hdl/tbk_cell.sv]
module tbk_cell (
  input  logic                clk,
  input  tbk_pkg::cell_ctrl_t ctrl,
  input  logic                beyond,
  input  tbk_pkg::cell_link_t prev_link,
  input  tbk_pkg::cell_link_t next_link,
  output tbk_pkg::cell_link_t link
);
  import tbk_pkg::*;

  temp_t hi_r, hi_nxt;
  temp_t lo_r, lo_nxt;
  logic  hi_hit, lo_hit;

  // A slot past the filled ones always hits and so takes the reading or its left
  // neighbour's entry; a filled slot hits only when the reading is strictly more
  // extreme, so equal values queue behind the kept copy.
  assign hi_hit = beyond || ($signed(ctrl.value) > $signed(hi_r));
  assign lo_hit = beyond || ($signed(ctrl.value) < $signed(lo_r));

  always_comb begin
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    unique case (ctrl.op)
      OP_INSERT: begin
        if (prev_link.hi_hit) begin
          hi_nxt = prev_link.hi_val;
        end else if (hi_hit) begin
          hi_nxt = ctrl.value;
        end
        if (prev_link.lo_hit) begin
          lo_nxt = prev_link.lo_val;
        end else if (lo_hit) begin
          lo_nxt = ctrl.value;
        end
      end
      OP_ROT_HI: hi_nxt = next_link.hi_val;
      OP_ROT_LO: lo_nxt = next_link.lo_val;
      OP_HOLD:   ;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
  end

  assign link.hi_val = hi_r;
  assign link.lo_val = lo_r;
  assign link.hi_hit = hi_hit;
  assign link.lo_hit = lo_hit;

endmodule

[hdl/top_bottom_k_tracker_top.sv]
// Streaming top-K / bottom-K tracker. Each add beat carries one temperature
// reading (signed, 4 fraction bits), which is clamped to -100.0..70.0 degrees
// and dropped into both a descending list of the KEEP highest and an ascending
// list of the KEEP lowest readings seen since reset; equal readings are all
// kept, exactly as a full sort would keep them. The lists live in a row of
// KEEP identical cells, cell i holding rank i of both lists, and an insert is
// a compare-and-shift in which every cell compares the reading with its own
// entries and takes either its left neighbour's entry, the reading, or keeps
// what it has. An add beat leaves the block ready, so the next beat is
// accepted straight away. A report beat produces 2*KEEP result beats: the high
// list from rank 0 downwards, then the low list from rank 0 upwards, the final
// beat marked with last. The report rotates the cell row one place per result
// beat, so cell 0 always presents the current rank, and after KEEP rotations
// each list is back where it started. A report occupies the block from its
// acceptance until its last result beat is loaded, and while a report is being
// read out no input beat is accepted. Slots that no reading has reached yet
// are returned with present low and a value of zero. The entries are not
// cleared by reset; the fill count and the control state are.
module top_bottom_k_tracker_top #(
  parameter int KEEP = 5
) (
  input  logic       clk,
  input  logic       rst_n,
  tbk_in_if.sink     in_beat,
  tbk_out_if.source  out_beat
);
  import tbk_pkg::*;

  localparam int CNT_W  = $clog2(KEEP + 1);
  localparam int RANK_W = (KEEP > 1) ? $clog2(KEEP) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  logic              list_r, list_nxt;
  logic [RANK_W-1:0] rank_r, rank_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  temp_t             out_value_r, out_value_nxt;
  logic              out_list_r, out_list_nxt;
  logic [RANK_OUT_W-1:0] out_rank_r, out_rank_nxt;
  logic              out_present_r, out_present_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_take;
  logic              load;
  logic              rank_end;
  logic              slot_present;
  temp_t             sat_value;
  logic [RANK_W+RANK_OUT_W-1:0] rank_ext;
  cell_ctrl_t        ctrl;
  cell_link_t        links [KEEP];

  // Handshakes. During a readout, a new result is loaded whenever the output
  // register is free or being emptied in the same cycle.
  assign in_beat.ready = (state_r == ST_IDLE);
  assign in_take       = in_beat.valid && in_beat.ready;
  assign load          = (state_r == ST_EMIT) && (!out_valid_r || out_beat.ready);
  assign rank_end      = (rank_r == RANK_W'(KEEP - 1));

  // Clamp the reading to the legal temperature range.
  always_comb begin
    if ($signed(in_beat.temperature) < $signed(TEMP_MIN)) begin
      sat_value = TEMP_MIN;
    end else if ($signed(in_beat.temperature) > $signed(TEMP_MAX)) begin
      sat_value = TEMP_MAX;
    end else begin
      sat_value = in_beat.temperature;
    end
  end

  // Broadcast command to the cell row.
  always_comb begin
    ctrl.value = sat_value;
    ctrl.op    = OP_HOLD;
    if (in_take && (in_beat.mode == MODE_ADD)) begin
      ctrl.op = OP_INSERT;
    end else if (load) begin
      ctrl.op = (list_r == LIST_LOW) ? OP_ROT_LO : OP_ROT_HI;
    end
  end

  // The row of cells. Cell 0 sees no left neighbour; the rightmost cell
  // wraps round to cell 0 so that a rotation is lossless.
  for (genvar i = 0; i < KEEP; i++) begin : g_cell
    cell_link_t prev_l;
    logic       beyond;

    if (i == 0) begin : g_first
      assign prev_l = LINK_NONE;
    end else begin : g_rest
      assign prev_l = links[i-1];
    end

    assign beyond = (CNT_W'(i) >= count_r);

    tbk_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .beyond    (beyond),
      .prev_link (prev_l),
      .next_link (links[(i + 1) % KEEP]),
      .link      (links[i])
    );
  end

  assign slot_present = (CNT_W'(rank_r) < count_r);
  assign rank_ext     = (RANK_W + RANK_OUT_W)'(rank_r);

  always_comb begin
    state_nxt       = state_r;
    list_nxt        = list_r;
    rank_nxt        = rank_r;
    count_nxt       = count_r;
    out_valid_nxt   = out_valid_r;
    out_value_nxt   = out_value_r;
    out_list_nxt    = out_list_r;
    out_rank_nxt    = out_rank_r;
    out_present_nxt = out_present_r;
    out_last_nxt    = out_last_r;

    if (out_beat.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_take) begin
      if (in_beat.mode == MODE_REPORT) begin
        state_nxt = ST_EMIT;
        list_nxt  = LIST_HIGH;
        rank_nxt  = '0;
      end else if (count_r < CNT_W'(KEEP)) begin
        count_nxt = count_r + 1'b1;
      end
    end

    if (load) begin
      out_valid_nxt   = 1'b1;
      out_list_nxt    = list_r;
      out_rank_nxt    = rank_ext[RANK_OUT_W-1:0];
      out_present_nxt = slot_present;
      out_last_nxt    = (list_r == LIST_LOW) && rank_end;
      if (!slot_present) begin
        out_value_nxt = '0;
      end else if (list_r == LIST_LOW) begin
        out_value_nxt = links[0].lo_val;
      end else begin
        out_value_nxt = links[0].hi_val;
      end

      if (rank_end) begin
        rank_nxt = '0;
        if (list_r == LIST_LOW) begin
          state_nxt = ST_IDLE;
          list_nxt  = LIST_HIGH;
        end else begin
          list_nxt = LIST_LOW;
        end
      end else begin
        rank_nxt = rank_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      list_r      <= LIST_HIGH;
      rank_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      list_r        <= list_nxt;
      rank_r        <= rank_nxt;
      count_r       <= count_nxt;
      out_valid_r   <= out_valid_nxt;
      out_value_r   <= out_value_nxt;
      out_list_r    <= out_list_nxt;
      out_rank_r    <= out_rank_nxt;
      out_present_r <= out_present_nxt;
      out_last_r    <= out_last_nxt;
    end
  end

  assign out_beat.valid    = out_valid_r;
  assign out_beat.value    = out_value_r;
  assign out_beat.list_sel = out_list_r;
  assign out_beat.rank     = out_rank_r;
  assign out_beat.present  = out_present_r;
  assign out_beat.last     = out_last_r;

  // The fill count saturates at the list length.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(KEEP))
    else $error("fill count beyond list length");

  // A report request always starts a readout in the next cycle.
  a_report_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && (in_beat.mode == MODE_REPORT)) |=> (state_r == ST_EMIT))
    else $error("report accepted but no readout started");

  // Loading the final low-list slot ends the readout.
  a_report_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (load && (list_r == LIST_LOW) && rank_end) |=> (state_r == ST_IDLE))
    else $error("readout did not finish after its final beat");

  // The marked final beat always belongs to the low list.
  a_last_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_beat.valid && out_beat.last) |-> (out_beat.list_sel == LIST_LOW))
    else $error("final beat is not from the low list");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

// Self-checking bench for the top-K / bottom-K tracker. Reading and report
// beats are queued by the stimulus process and presented by a falling-edge
// driver; a rising-edge monitor updates a private model of both lists on
// every accepted input beat and compares each accepted result beat, field
// by field, with the oldest predicted one.
module tb_top;
  import tbk_pkg::*;

  localparam int KEEP       = 5;
  localparam int CYCLE_CAP  = 200000;
  localparam int LONG_HOLD  = 150;
  localparam int RAND_ITEMS = 300;
  localparam int CALM_TAIL  = 40;

  // One pending input beat, with two bench-only flags: wait_drain makes the
  // driver hold it back until every predicted result has arrived, and
  // hold_out asks the result side to stop taking beats once it is accepted.
  typedef struct packed {
    logic  mode;
    temp_t temp;
    logic  wait_drain;
    logic  hold_out;
  } reading_req_t;

  typedef struct packed {
    temp_t                 value;
    logic                  list_sel;
    logic [RANK_OUT_W-1:0] rank;
    logic                  present;
    logic                  last;
  } report_beat_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Everything the bench drives is held in variables with known start values,
  // so that no input of the block is ever unknown.
  logic         src_valid = 1'b0;
  logic         snk_ready = 1'b0;
  reading_req_t offered   = '0;

  tbk_in_if  in_if ();
  tbk_out_if out_if ();

  assign in_if.valid       = src_valid;
  assign in_if.mode        = offered.mode;
  assign in_if.temperature = offered.temp;
  assign out_if.ready      = snk_ready;

  top_bottom_k_tracker_top #(
    .KEEP(KEEP)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_beat (in_if),
    .out_beat(out_if)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Model of the tracker: kept[LIST_HIGH] runs from the highest reading
  // downwards, kept[LIST_LOW] from the lowest upwards, and fill counts the
  // readings held, stopping at KEEP.
  temp_t kept [2][KEEP];
  int    fill = 0;

  reading_req_t pend_q [$];
  report_beat_t report_q [$];

  int   mismatches = 0;
  int   cycles     = 0;
  int   in_gap     = 0;
  int   out_gap    = 0;
  int   hold_left  = 0;
  int   hold_req   = 0;
  int   hold_seen  = 0;
  logic in_taken   = 1'b0;
  logic calm       = 1'b0;

  initial begin
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < KEEP; i++) begin
        kept[s][i] = '0;
      end
    end
  end

  // Drop one saturated reading into one list. A reading equal to a kept one
  // goes after it, and whatever falls off the far end is lost.
  task automatic place(input logic sel, input temp_t v);
    int  pos;
    int  j;
    logic ahead;
    pos = fill;
    for (j = 0; j < fill; j++) begin
      ahead = (sel == LIST_HIGH) ? (v > kept[sel][j]) : (v < kept[sel][j]);
      if (ahead && pos == fill) begin
        pos = j;
      end
    end
    if (pos < KEEP) begin
      for (j = (fill < KEEP) ? fill : KEEP - 1; j > pos; j--) begin
        kept[sel][j] = kept[sel][j-1];
      end
      kept[sel][pos] = v;
    end
  endtask

  // Work out what one accepted input beat does: a reading updates both lists,
  // a report queues 2*KEEP result beats and leaves the lists alone.
  task automatic track_beat(input reading_req_t item);
    temp_t        v;
    report_beat_t b;
    logic         sel;
    if (item.mode == MODE_ADD) begin
      v = item.temp;
      if (v < TEMP_MIN) begin
        v = TEMP_MIN;
      end
      if (v > TEMP_MAX) begin
        v = TEMP_MAX;
      end
      place(LIST_HIGH, v);
      place(LIST_LOW, v);
      if (fill < KEEP) begin
        fill++;
      end
    end else begin
      for (int s = 0; s < 2; s++) begin
        sel = (s == 0) ? LIST_HIGH : LIST_LOW;
        for (int i = 0; i < KEEP; i++) begin
          b.present  = (i < fill);
          b.value    = b.present ? kept[sel][i] : '0;
          b.list_sel = sel;
          b.rank     = i[RANK_OUT_W-1:0];
          b.last     = (sel == LIST_LOW) && (i == KEEP - 1);
          report_q   = {report_q, b};
        end
      end
    end
  endtask

  task automatic cmp_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: everything is sampled at the rising edge, where the bench's own
  // inputs have been stable since the previous falling edge. The input side
  // is handled first so that a report's beats are predicted before any check.
  always @(posedge clk) begin
    report_beat_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        track_beat(offered);
        if (offered.hold_out) begin
          hold_req++;
        end
      end
      if (out_if.valid && out_if.ready) begin
        if (report_q.size() == 0) begin
          $error("result beat with nothing predicted: value %0d list %0d rank %0d",
                 out_if.value, out_if.list_sel, out_if.rank);
          mismatches++;
        end else begin
          want = report_q.pop_front();
          cmp_field("value", int'(want.value), int'(out_if.value));
          cmp_field("list_sel", want.list_sel, out_if.list_sel);
          cmp_field("rank", want.rank, out_if.rank);
          cmp_field("present", want.present, out_if.present);
          cmp_field("last", want.last, out_if.last);
        end
      end
    end
  end

  // Driver: a beat on offer stays put until it has been taken. Between beats
  // the sender may go quiet for a random burst, except in the calm tail, and
  // a beat flagged wait_drain is held back until all results are in.
  always @(negedge clk) begin
    logic nxt_valid;
    if (rst_n) begin
      if (!src_valid || in_taken) begin
        nxt_valid = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (pend_q.size() > 0 &&
                     !(pend_q[0].wait_drain && report_q.size() != 0)) begin
          offered   <= pend_q.pop_front();
          nxt_valid = 1'b1;
          if (!calm && $urandom_range(0, 5) == 0) begin
            in_gap = $urandom_range(1, 9);
          end
        end
        src_valid <= nxt_valid;
      end
    end
  end

  // Result side ready. A hold request from the monitor starts one long
  // stretch without ready, during which the block fills and refuses input;
  // otherwise ready drops in short random bursts, none in the calm tail.
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      snk_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      snk_ready <= 1'b0;
    end else begin
      snk_ready <= 1'b1;
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(1, 9);
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("FAIL top_bottom_k_tracker_top");
      $finish;
    end
  end

  function automatic temp_t rand12();
    logic [31:0] u;
    u = $urandom;
    return u[TEMP_W-1:0];
  endfunction

  // Random reading, mostly close to the weakest kept entry of either list so
  // that insertions land at every rank, with some exact copies of kept
  // entries and some raw 12-bit patterns that often need saturating.
  function automatic temp_t pick_reading();
    int          r;
    int          t;
    logic [31:0] u;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      return rand12();
    end
    if (r < 25) begin
      return kept[$urandom_range(0, 1)][$urandom_range(0, KEEP - 1)];
    end
    if (r < 62) begin
      t = int'(kept[LIST_HIGH][KEEP-1]) - 10 + int'($urandom_range(0, 14));
    end else begin
      t = int'(kept[LIST_LOW][KEEP-1]) + 10 - int'($urandom_range(0, 14));
    end
    if (t > 2047) begin
      t = 2047;
    end
    if (t < -2048) begin
      t = -2048;
    end
    u = t;
    return u[TEMP_W-1:0];
  endfunction

  task automatic push_req(input logic mode, input temp_t t, input logic drain,
                          input logic hold);
    reading_req_t item;
    item.mode       = mode;
    item.temp       = t;
    item.wait_drain = drain;
    item.hold_out   = hold;
    pend_q          = {pend_q, item};
  endtask

  initial begin
    reading_req_t item;
    int           n;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. A report on an empty tracker shows every slot absent,
    // then the lists are filled one reading at a time with reports between,
    // covering duplicates, insertion in the middle and at the head.
    push_req(MODE_REPORT, rand12(), 1'b0, 1'b0);
    push_req(MODE_ADD, 12'sd100, 1'b0, 1'b0);
    push_req(MODE_REPORT, rand12(), 1'b0, 1'b0);
    push_req(MODE_ADD, 12'sd100, 1'b0, 1'b0);
    push_req(MODE_ADD, -12'sd50, 1'b0, 1'b0);
    push_req(MODE_REPORT, rand12(), 1'b0, 1'b0);
    push_req(MODE_ADD, 12'sd300, 1'b0, 1'b0);
    push_req(MODE_ADD, 12'sd200, 1'b0, 1'b0);
    push_req(MODE_REPORT, rand12(), 1'b0, 1'b0);
    push_req(MODE_ADD, 12'sd250, 1'b0, 1'b0);
    push_req(MODE_ADD, -12'sd60, 1'b0, 1'b0);
    push_req(MODE_REPORT, rand12(), 1'b0, 1'b0);
    // Field extremes and the saturation limits, both exactly at and just outside.
    push_req(MODE_ADD, 12'sh7FF, 1'b0, 1'b0);
    push_req(MODE_ADD, 12'sh800, 1'b0, 1'b0);
    push_req(MODE_ADD, 12'sd1121, 1'b0, 1'b0);
    push_req(MODE_ADD, -12'sd1601, 1'b0, 1'b0);
    push_req(MODE_ADD, TEMP_MAX, 1'b0, 1'b0);
    push_req(MODE_ADD, TEMP_MIN, 1'b0, 1'b0);
    push_req(MODE_REPORT, rand12(), 1'b0, 1'b0);
    // Long result-side hold while more beats are offered behind the report,
    // then a report sent only once everything has drained.
    push_req(MODE_REPORT, rand12(), 1'b0, 1'b1);
    push_req(MODE_ADD, 12'sd0, 1'b0, 1'b0);
    push_req(MODE_REPORT, rand12(), 1'b0, 1'b0);
    push_req(MODE_ADD, 12'sd5, 1'b0, 1'b0);
    push_req(MODE_REPORT, rand12(), 1'b1, 1'b0);

    // Random part, topped up a few beats ahead of the driver so that the
    // readings follow the lists as they move.
    for (n = 0; n < RAND_ITEMS; n++) begin
      while (pend_q.size() >= 4) @(posedge clk);
      calm            = (n >= RAND_ITEMS - CALM_TAIL);
      item.mode       = ($urandom_range(0, 99) < 15 || n == 120) ? MODE_REPORT : MODE_ADD;
      item.temp       = pick_reading();
      item.wait_drain = (n % 70 == 69);
      item.hold_out   = (n == 120);
      pend_q          = {pend_q, item};
    end

    while (pend_q.size() != 0 || src_valid) @(posedge clk);
    while (report_q.size() != 0) @(posedge clk);
    // Wait on after the last result for any stray beats.
    repeat (30) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASS top_bottom_k_tracker_top");
    end else begin
      $display("FAIL top_bottom_k_tracker_top");
    end
    $finish;
  end

endmodule
